### rtl/core/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and saturation helper for the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

    // operation codes
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = 32;
    localparam int MAG_BITS  = 65;
    localparam int DEN_BITS  = 64;
    localparam int REM_BITS  = MAG_BITS + FRAC_BITS;

    // side data traveling alongside the divider
    typedef struct packed {
        t_mode       mode;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        ovf;
    } t_side;

    // saturate a wide signed value to 32 bits, msb of the result is overflow
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

### rtl/core/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// ---------------------------------------------------------------------------
// Usage:
//   Drive i_mode and the four operand parts and raise start; a word is
//   taken at every rising edge with start high. busy is always low, so a
//   new word may be issued in every cycle.
//   Each result appears on o_res_re, o_res_im, o_div_by_zero and
//   o_overflow for one cycle, marked by o_done, in issue order. Every mode
//   takes the same latency. Throughput is one word per cycle. A word
//   passes through four stages of operand, product, sum and
//   sign/saturation work, then 32 restoring-divider stages (one quotient
//   bit each), then the output register.
//   Reset clears only the valid bits; words in flight are dropped.
//   The receiver cannot hold results off, so nothing stalls.
//   Divide by zero gives zero parts with o_div_by_zero set; any part out
//   of 32-bit range saturates and sets o_overflow.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_done,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_div_by_zero,
    output logic               o_overflow
);

    localparam int ND    = cau_pkg::QUO_BITS;
    localparam int MAG_W = cau_pkg::MAG_BITS;

    assign busy = 1'b0;

    // stage 1: operand registers
    logic               r_v1;
    cau_pkg::t_mode     r_mode1;
    logic signed [31:0] r_ar, r_ai, r_br, r_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= cau_pkg::t_mode'(i_mode);
        r_ar    <= i_a_re;
        r_ai    <= i_a_im;
        r_br    <= i_b_re;
        r_bi    <= i_b_im;
    end

    // stage 2: products and part sums
    logic               r_v2;
    cau_pkg::t_mode     r_mode2;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb_r, r_p_bb_i;
    logic signed [32:0] r_s_re, r_s_im;
    logic signed [63:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir, n_p_bb_r, n_p_bb_i;
    logic signed [32:0] n_s_re, n_s_im;

    always_comb begin
        n_p_rr   = r_ar * r_br;
        n_p_ii   = r_ai * r_bi;
        n_p_ri   = r_ar * r_bi;
        n_p_ir   = r_ai * r_br;
        n_p_bb_r = r_br * r_br;
        n_p_bb_i = r_bi * r_bi;
        if (r_mode1 == cau_pkg::MODE_SUB) begin
            n_s_re = {r_ar[31], r_ar} - {r_br[31], r_br};
            n_s_im = {r_ai[31], r_ai} - {r_bi[31], r_bi};
        end else begin
            n_s_re = {r_ar[31], r_ar} + {r_br[31], r_br};
            n_s_im = {r_ai[31], r_ai} + {r_bi[31], r_bi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode2  <= r_mode1;
        r_p_rr   <= n_p_rr;
        r_p_ii   <= n_p_ii;
        r_p_ri   <= n_p_ri;
        r_p_ir   <= n_p_ir;
        r_p_bb_r <= n_p_bb_r;
        r_p_bb_i <= n_p_bb_i;
        r_s_re   <= n_s_re;
        r_s_im   <= n_s_im;
    end

    // stage 3: exact product sums and divisor
    logic               r_v3;
    cau_pkg::t_mode     r_mode3;
    logic signed [65:0] r_x_re, r_x_im;
    logic [63:0]        r_den;
    logic signed [32:0] r_s3_re, r_s3_im;
    logic signed [65:0] e_rr, e_ii, e_ri, e_ir;
    logic signed [65:0] n_x_re, n_x_im;
    logic [63:0]        n_den;

    always_comb begin
        e_rr  = {{2{r_p_rr[63]}}, r_p_rr};
        e_ii  = {{2{r_p_ii[63]}}, r_p_ii};
        e_ri  = {{2{r_p_ri[63]}}, r_p_ri};
        e_ir  = {{2{r_p_ir[63]}}, r_p_ir};
        n_den = 64'(r_p_bb_r) + 64'(r_p_bb_i);
        if (r_mode2 == cau_pkg::MODE_MUL) begin
            n_x_re = e_rr - e_ii;
            n_x_im = e_ri + e_ir;
        end else begin
            n_x_re = e_rr + e_ii;
            n_x_im = e_ir - e_ri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode3 <= r_mode2;
        r_x_re  <= n_x_re;
        r_x_im  <= n_x_im;
        r_den   <= n_den;
        r_s3_re <= r_s_re;
        r_s3_im <= r_s_im;
    end

    // stage 4: non-divide results, divide magnitudes and range flags
    logic                              r_v4;
    cau_pkg::t_side                    r_side4;
    logic [cau_pkg::MAG_BITS-1:0]      r_mag_re, r_mag_im;
    logic [cau_pkg::DEN_BITS-1:0]      r_den4;
    cau_pkg::t_side                    n_side;
    logic [cau_pkg::MAG_BITS-1:0]      n_mag_re, n_mag_im;
    logic signed [65:0]                c_sh_re, c_sh_im;
    logic [32:0]                       c_sat_re, c_sat_im;
    logic [cau_pkg::REM_BITS-1:0]      c_den_sh;

    always_comb begin
        c_sh_re  = r_x_re >>> cau_pkg::FRAC_BITS;
        c_sh_im  = r_x_im >>> cau_pkg::FRAC_BITS;
        if (r_mode3 == cau_pkg::MODE_MUL) begin
            c_sat_re = cau_pkg::sat32(c_sh_re);
            c_sat_im = cau_pkg::sat32(c_sh_im);
        end else begin
            c_sat_re = cau_pkg::sat32({{33{r_s3_re[32]}}, r_s3_re});
            c_sat_im = cau_pkg::sat32({{33{r_s3_im[32]}}, r_s3_im});
        end
        n_mag_re = r_x_re[65] ? MAG_W'(-r_x_re) : MAG_W'(r_x_re);
        n_mag_im = r_x_im[65] ? MAG_W'(-r_x_im) : MAG_W'(r_x_im);
        c_den_sh = {1'b0, r_den, {cau_pkg::FRAC_BITS{1'b0}}};
        n_side.mode   = r_mode3;
        n_side.dz     = (r_den == '0);
        n_side.neg_re = r_x_re[65];
        n_side.neg_im = r_x_im[65];
        n_side.big_re = {{cau_pkg::FRAC_BITS{1'b0}}, n_mag_re} >= c_den_sh;
        n_side.big_im = {{cau_pkg::FRAC_BITS{1'b0}}, n_mag_im} >= c_den_sh;
        n_side.res_re = c_sat_re[31:0];
        n_side.res_im = c_sat_im[31:0];
        n_side.ovf    = c_sat_re[32] | c_sat_im[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side4  <= n_side;
        r_mag_re <= n_mag_re;
        r_mag_im <= n_mag_im;
        r_den4   <= r_den;
    end

    // divider pipelines, one per part
    logic                          d_v_re, d_v_im;
    logic [cau_pkg::QUO_BITS-1:0]  d_q_re, d_q_im;

    cau_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_mag   (r_mag_re),
        .i_den   (r_den4),
        .o_valid (d_v_re),
        .o_quo   (d_q_re)
    );

    cau_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_mag   (r_mag_im),
        .i_den   (r_den4),
        .o_valid (d_v_im),
        .o_quo   (d_q_im)
    );

    // side data delay line matching the divider depth
    cau_pkg::t_side r_side [ND];

    always_ff @(posedge i_clk) begin
        r_side[0] <= r_side4;
        for (int k = 1; k < ND; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // output stage: sign, saturate and select by mode
    cau_pkg::t_side     c_sd;
    logic signed [65:0] c_qv_re, c_qv_im;
    logic [32:0]        c_q_re, c_q_im;
    logic [31:0]        n_res_re, n_res_im;
    logic               n_dz, n_ovf;

    always_comb begin
        c_sd    = r_side[ND-1];
        c_qv_re = c_sd.big_re ? (66'sd1 <<< 33) : $signed({34'b0, d_q_re});
        c_qv_im = c_sd.big_im ? (66'sd1 <<< 33) : $signed({34'b0, d_q_im});
        c_q_re  = cau_pkg::sat32(c_sd.neg_re ? -c_qv_re : c_qv_re);
        c_q_im  = cau_pkg::sat32(c_sd.neg_im ? -c_qv_im : c_qv_im);
        if (c_sd.mode != cau_pkg::MODE_DIV) begin
            n_res_re = c_sd.res_re;
            n_res_im = c_sd.res_im;
            n_dz     = 1'b0;
            n_ovf    = c_sd.ovf;
        end else if (c_sd.dz) begin
            n_res_re = '0;
            n_res_im = '0;
            n_dz     = 1'b1;
            n_ovf    = 1'b0;
        end else begin
            n_res_re = c_q_re[31:0];
            n_res_im = c_q_im[31:0];
            n_dz     = 1'b0;
            n_ovf    = c_q_re[32] | c_q_im[32];
        end
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_v_re & d_v_im;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res_re      <= n_res_re;
        o_res_im      <= n_res_im;
        o_div_by_zero <= n_dz;
        o_overflow    <= n_ovf;
    end

    assign o_done = r_done;

endmodule

### rtl/core/cau_div.sv
// ---------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider: quotient of (mag * 2^16) / den, one bit per stage.
// ---------------------------------------------------------------------------
module cau_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [cau_pkg::MAG_BITS-1:0]   i_mag,
    input  logic [cau_pkg::DEN_BITS-1:0]   i_den,
    output logic                           o_valid,
    output logic [cau_pkg::QUO_BITS-1:0]   o_quo
);

    localparam int NS = cau_pkg::QUO_BITS;
    localparam int CW = cau_pkg::DEN_BITS + cau_pkg::QUO_BITS;

    logic                           r_v   [NS];
    logic [cau_pkg::REM_BITS-1:0]   r_rem [NS];
    logic [cau_pkg::DEN_BITS-1:0]   r_den [NS];
    logic [NS-1:0]                  r_q   [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic                         p_v;
            logic [cau_pkg::REM_BITS-1:0] p_rem;
            logic [cau_pkg::DEN_BITS-1:0] p_den;
            logic [NS-1:0]                p_q;
            logic [CW-1:0]                c_rem;
            logic [CW-1:0]                c_div;
            logic [CW-1:0]                c_diff;
            logic                         c_ge;

            // previous stage or input word
            if (k == 0) begin : g_first
                assign p_v   = i_valid;
                assign p_rem = {i_mag, {cau_pkg::FRAC_BITS{1'b0}}};
                assign p_den = i_den;
                assign p_q   = '0;
            end else begin : g_next
                assign p_v   = r_v[k-1];
                assign p_rem = r_rem[k-1];
                assign p_den = r_den[k-1];
                assign p_q   = r_q[k-1];
            end

            // trial subtract of the shifted divisor
            assign c_rem  = CW'(p_rem);
            assign c_div  = CW'(p_den) << (NS - 1 - k);
            assign c_ge   = c_rem >= c_div;
            assign c_diff = c_rem - c_div;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k] <= c_ge ? c_diff[cau_pkg::REM_BITS-1:0] : p_rem;
                r_den[k] <= p_den;
                r_q[k]   <= p_q | (c_ge ? (NS'(1) << (NS - 1 - k)) : '0);
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_q[NS-1];

endmodule
